@@ hw/rtl/tilemap_box_collision_unit_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the tilemap box collision unit
// Each macro checks a property on the rising edge of the given clock and is
// switched off while the given active-low reset is asserted.
// ----------------------------------------------------------------------------
`ifndef TILEMAP_BOX_COLLISION_UNIT_MACROS_SVH
`define TILEMAP_BOX_COLLISION_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TBC_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tilemap box collision unit: same-cycle check failed");

// The consequent must hold starting in the cycle after the antecedent.
`define TBC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tilemap box collision unit: next-cycle check failed");

`endif

@@ hw/rtl/tbc_pkg.sv @@
// ----------------------------------------------------------------------------
// tbc_pkg
// Types and fixed widths shared by the tilemap box collision unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tbc_pkg;

    localparam int TYPE_W    = 4;   // tile type code
    localparam int GRID_W    = 6;   // col and row fields of a write
    localparam int COORD_W   = 11;  // box_x, box_y
    localparam int DIM_W     = 8;   // box_w, box_h
    localparam int PIX_W     = 12;  // pixel sums such as box_x + box_w
    localparam int DIVR_W    = 9;   // tile size in pixels, up to 256
    localparam int REM_W     = 8;   // remainder of a division by the tile size
    localparam int RECIP_SH  = 20;  // binary point of a tile size reciprocal
    localparam int RECIP_W   = 19;  // reciprocal of a tile size of 4 or more

    localparam int S_TDATA_W = 56;
    localparam int M_TDATA_W = 8;

    // Field positions in the slave-side tdata, lowest bit of each field.
    localparam int COL_LSB   = 0;
    localparam int ROW_LSB   = COL_LSB + GRID_W;
    localparam int TYPE_LSB  = ROW_LSB + GRID_W;
    localparam int BOXX_LSB  = TYPE_LSB + TYPE_W;
    localparam int BOXY_LSB  = BOXX_LSB + COORD_W;
    localparam int BOXW_LSB  = BOXY_LSB + COORD_W;
    localparam int BOXH_LSB  = BOXW_LSB + DIM_W;

    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DIVX_GO,
        ST_DIVX_RUN,
        ST_DIVY_GO,
        ST_DIVY_RUN,
        ST_SCAN,
        ST_RESP
    } state_t;

    typedef struct packed {
        logic                 start;
        logic [COORD_W-1:0]   dividend;
        logic [DIVR_W-1:0]    divisor;
        logic [RECIP_W-1:0]   recip;
    } div_req_t;

    typedef struct packed {
        logic                 done;
        logic [COORD_W-1:0]   quot;
        logic [REM_W-1:0]     rem;
    } div_rsp_t;

endpackage

@@ hw/rtl/tbc_div.sv @@
// ----------------------------------------------------------------------------
// tbc_div
// Shared divider by a tile size: the quotient comes from a multiplication by
// the scaled reciprocal of the tile size, the remainder from multiplying back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tbc_div
    import tbc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic                        step1_reg;
    logic                        step2_reg;
    logic                        done_reg;
    logic [COORD_W-1:0]          num_reg;
    logic [DIVR_W-1:0]           dv_reg;
    logic [RECIP_W-1:0]          rcp_reg;
    logic [COORD_W-1:0]          q_reg;
    logic [COORD_W-1:0]          q_next;
    logic [REM_W-1:0]            rem_reg;
    logic [REM_W-1:0]            rem_next;
    logic [COORD_W+RECIP_W-1:0]  prod;
    logic [COORD_W+DIVR_W-1:0]   back;
    logic [COORD_W-1:0]          diff;

    // Start is followed by step1, step2 and done: the quotient is registered
    // on step1, the remainder on step2, and done is raised after that.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step1_reg <= 1'b0;
            step2_reg <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            step1_reg <= req.start;
            step2_reg <= step1_reg;
            done_reg  <= step2_reg;
        end
    end

    // The reciprocal is rounded up with enough fraction bits that the
    // quotient is exact for every 11-bit dividend. The remainder always stays
    // below the divisor, so eight bits hold it.
    always_comb
    begin
        prod     = num_reg * rcp_reg;
        q_next   = COORD_W'(prod >> RECIP_SH);
        back     = q_reg * dv_reg;
        diff     = num_reg - back[COORD_W-1:0];
        rem_next = diff[REM_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            num_reg <= req.dividend;
            dv_reg  <= req.divisor;
            rcp_reg <= req.recip;
        end
        if (step1_reg)
        begin
            q_reg <= q_next;
        end
        if (step2_reg)
        begin
            rem_reg <= rem_next;
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quot = q_reg;
    assign rsp.rem  = rem_reg;

endmodule

@@ hw/rtl/tbc_map.sv @@
// ----------------------------------------------------------------------------
// tbc_map
// Tile type memory: one write port and one read port with registered data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tbc_map
    import tbc_pkg::*;
#(
    parameter int AW = 12
)
(
    input  logic              clk,
    input  logic              we,
    input  logic [AW-1:0]     waddr,
    input  logic [TYPE_W-1:0] wdata,
    input  logic [AW-1:0]     raddr,
    output logic [TYPE_W-1:0] rdata
);

    logic [TYPE_W-1:0] mem [2**AW];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

@@ hw/rtl/tilemap_box_collision_unit.sv @@
// ----------------------------------------------------------------------------
// tilemap_box_collision_unit
// Tile map with a strict axis-aligned box collision query.
// ----------------------------------------------------------------------------
// After reset the map is swept to type 0, one cell per cycle, over all
// 2**(clog2(MAP_COLS) + clog2(MAP_ROWS)) cells (4096 by default); no transfer
// is accepted until the sweep ends, while configuration writes are taken at
// any time. A write item is stored, if inside the grid, in the cycle that
// takes it. A query first finds its start column and start row with a shared
// divider that multiplies by a scaled reciprocal of the tile size, then reads
// the map once per cycle for each tile that overlaps the box inside the grid,
// and stops at the first non-empty one, reading at most 9 x 9 tiles at the
// default 32 x 32 pixel tiles. One item is in work at a time; its result
// waits in an output register, so the next item is accepted as soon as the
// result is loaded there.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tilemap_box_collision_unit
    import tbc_pkg::*;
#(
    parameter int TILE_W   = 32,
    parameter int TILE_H   = 32,
    parameter int MAP_COLS = 64,
    parameter int MAP_ROWS = 64
)
(
    input  logic                 clk,
    input  logic                 rst_n,

    input  logic                 cfg_wr_en,
    input  logic [TYPE_W-1:0]    cfg_wr_data,    // empty_tile_type

    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // col[5:0], row[11:6], tile_type[15:12], box_x[26:16], box_y[37:27],
    // box_w[45:38], box_h[53:46], zero fill[55:54]
    input  logic [S_TDATA_W-1:0] s_axis_tdata,
    input  logic                 s_axis_tuser,   // action

    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [M_TDATA_W-1:0] m_axis_tdata    // touching[0], zero fill[7:1]
);

    localparam int CB = $clog2(MAP_COLS);
    localparam int RB = $clog2(MAP_ROWS);
    localparam int AW = CB + RB;

    localparam logic [COORD_W-1:0] COLS_Q     = COORD_W'(MAP_COLS);
    localparam logic [COORD_W-1:0] ROWS_Q     = COORD_W'(MAP_ROWS);
    localparam logic [PIX_W-1:0]   TILE_W_PX  = PIX_W'(TILE_W);
    localparam logic [PIX_W-1:0]   TILE_H_PX  = PIX_W'(TILE_H);
    localparam logic [DIVR_W-1:0]  TILE_W_DV  = DIVR_W'(TILE_W);
    localparam logic [DIVR_W-1:0]  TILE_H_DV  = DIVR_W'(TILE_H);
    localparam logic [RECIP_W-1:0] TILE_W_RCP =
        RECIP_W'(((1 << RECIP_SH) + TILE_W - 1) / TILE_W);
    localparam logic [RECIP_W-1:0] TILE_H_RCP =
        RECIP_W'(((1 << RECIP_SH) + TILE_H - 1) / TILE_H);

    state_t state_reg, state_next;

    logic [TYPE_W-1:0]  empty_reg;
    logic [AW-1:0]      clr_reg, clr_next;
    logic [COORD_W-1:0] x_reg, x_next;
    logic [COORD_W-1:0] y_reg, y_next;
    logic [PIX_W-1:0]   xe_reg, xe_next;
    logic [PIX_W-1:0]   ye_reg, ye_next;
    logic [COORD_W-1:0] cs_reg, cs_next;
    logic [PIX_W-1:0]   cx0_reg, cx0_next;
    logic [COORD_W-1:0] c_reg, c_next;
    logic [PIX_W-1:0]   cx_reg, cx_next;
    logic [COORD_W-1:0] r_reg, r_next;
    logic [PIX_W-1:0]   ry_reg, ry_next;
    logic               pend_reg, pend_next;
    logic               res_reg, res_next;
    logic               out_valid_reg, out_valid_next;
    logic               touching_reg, touching_next;

    logic               in_action;
    logic [COORD_W-1:0] in_col;
    logic [COORD_W-1:0] in_row;
    logic [TYPE_W-1:0]  in_type;
    logic [COORD_W-1:0] in_x;
    logic [COORD_W-1:0] in_y;
    logic [DIM_W-1:0]   in_w;
    logic [DIM_W-1:0]   in_h;

    logic               in_xfer;
    logic               out_free;
    logic               col_ok;
    logic               row_ok;
    logic               hit;
    logic [COORD_W-1:0] c_inc;
    logic [PIX_W-1:0]   cx_inc;

    div_req_t           div_req;
    div_rsp_t           div_rsp;

    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    logic [TYPE_W-1:0]  mem_wdata;
    logic [AW-1:0]      mem_raddr;
    logic [TYPE_W-1:0]  mem_rdata;

    assign in_action = s_axis_tuser;
    assign in_col    = COORD_W'(s_axis_tdata[COL_LSB +: GRID_W]);
    assign in_row    = COORD_W'(s_axis_tdata[ROW_LSB +: GRID_W]);
    assign in_type   = s_axis_tdata[TYPE_LSB +: TYPE_W];
    assign in_x      = s_axis_tdata[BOXX_LSB +: COORD_W];
    assign in_y      = s_axis_tdata[BOXY_LSB +: COORD_W];
    assign in_w      = s_axis_tdata[BOXW_LSB +: DIM_W];
    assign in_h      = s_axis_tdata[BOXH_LSB +: DIM_W];

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign out_free      = !out_valid_reg || m_axis_tready;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(M_TDATA_W-1){1'b0}}, touching_reg};

    // Scan window: the first column and row are the ones holding the box's
    // left and top edges; a tile belongs to the scan only while its left or
    // top pixel lies before the box's far edge.
    assign col_ok    = (c_reg < COLS_Q) && (cx_reg < xe_reg);
    assign row_ok    = (r_reg < ROWS_Q) && (ry_reg < ye_reg);
    assign hit       = pend_reg && (mem_rdata != empty_reg);
    assign c_inc     = c_reg + 1'b1;
    assign cx_inc    = cx_reg + TILE_W_PX;
    assign mem_raddr = {r_reg[RB-1:0], c_reg[CB-1:0]};

    tbc_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    tbc_map #(
        .AW (AW)
    ) u_map (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            empty_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            empty_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg        <= x_next;
        y_reg        <= y_next;
        xe_reg       <= xe_next;
        ye_reg       <= ye_next;
        cs_reg       <= cs_next;
        cx0_reg      <= cx0_next;
        c_reg        <= c_next;
        cx_reg       <= cx_next;
        r_reg        <= r_next;
        ry_reg       <= ry_next;
        res_reg      <= res_next;
        touching_reg <= touching_next;
    end

    always_comb
    begin
        state_next       = state_reg;
        clr_next         = clr_reg;
        x_next           = x_reg;
        y_next           = y_reg;
        xe_next          = xe_reg;
        ye_next          = ye_reg;
        cs_next          = cs_reg;
        cx0_next         = cx0_reg;
        c_next           = c_reg;
        cx_next          = cx_reg;
        r_next           = r_reg;
        ry_next          = ry_reg;
        pend_next        = 1'b0;
        res_next         = res_reg;
        out_valid_next   = out_valid_reg;
        touching_next    = touching_reg;

        div_req.start    = 1'b0;
        div_req.dividend = x_reg;
        div_req.divisor  = TILE_W_DV;
        div_req.recip    = TILE_W_RCP;

        mem_we           = 1'b0;
        mem_waddr        = {in_row[RB-1:0], in_col[CB-1:0]};
        mem_wdata        = in_type;

        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                mem_wdata = '0;
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == {AW{1'b1}})
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    res_next = 1'b0;
                    if (in_action == ACT_WRITE)
                    begin
                        // Writes outside the grid are dropped.
                        mem_we     = (in_col < COLS_Q) && (in_row < ROWS_Q);
                        state_next = ST_RESP;
                    end
                    else
                    begin
                        // A box of zero width or height still touches a tile
                        // whose open interior holds its edge, so it is
                        // scanned like any other box.
                        x_next     = in_x;
                        y_next     = in_y;
                        xe_next    = PIX_W'(in_x) + PIX_W'(in_w);
                        ye_next    = PIX_W'(in_y) + PIX_W'(in_h);
                        state_next = ST_DIVX_GO;
                    end
                end
            end

            ST_DIVX_GO:
            begin
                div_req.start = 1'b1;
                state_next    = ST_DIVX_RUN;
            end

            ST_DIVX_RUN:
            begin
                if (div_rsp.done)
                begin
                    cs_next    = div_rsp.quot;
                    c_next     = div_rsp.quot;
                    cx0_next   = PIX_W'(x_reg) - PIX_W'(div_rsp.rem);
                    cx_next    = PIX_W'(x_reg) - PIX_W'(div_rsp.rem);
                    state_next = ST_DIVY_GO;
                end
            end

            ST_DIVY_GO:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = y_reg;
                div_req.divisor  = TILE_H_DV;
                div_req.recip    = TILE_H_RCP;
                state_next       = ST_DIVY_RUN;
            end

            ST_DIVY_RUN:
            begin
                div_req.dividend = y_reg;
                div_req.divisor  = TILE_H_DV;
                div_req.recip    = TILE_H_RCP;
                if (div_rsp.done)
                begin
                    r_next     = div_rsp.quot;
                    ry_next    = PIX_W'(y_reg) - PIX_W'(div_rsp.rem);
                    state_next = ST_SCAN;
                end
            end

            ST_SCAN:
            begin
                // The read issued last cycle is checked while the next one
                // goes out; the first non-empty tile ends the query.
                if (hit)
                begin
                    res_next   = 1'b1;
                    state_next = ST_RESP;
                end
                else if (col_ok && row_ok)
                begin
                    pend_next = 1'b1;
                    if ((c_inc < COLS_Q) && (cx_inc < xe_reg))
                    begin
                        c_next  = c_inc;
                        cx_next = cx_inc;
                    end
                    else
                    begin
                        c_next  = cs_reg;
                        cx_next = cx0_reg;
                        r_next  = r_reg + 1'b1;
                        ry_next = ry_reg + TILE_H_PX;
                    end
                end
                else
                begin
                    res_next   = 1'b0;
                    state_next = ST_RESP;
                end
            end

            ST_RESP:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    touching_next  = res_reg;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

@@ hw/rtl/tbc_checker.sv @@
// ----------------------------------------------------------------------------
// tbc_checker
// Port-level checks of the tilemap box collision unit, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "tilemap_box_collision_unit_macros.svh"

module tbc_checker
    import tbc_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 s_axis_tvalid,
    input logic                 s_axis_tready,
    input logic                 s_axis_tuser,
    input logic                 m_axis_tvalid,
    input logic                 m_axis_tready,
    input logic [M_TDATA_W-1:0] m_axis_tdata
);

    logic in_xfer;
    logic out_busy;

    assign in_xfer  = s_axis_tvalid && s_axis_tready;
    assign out_busy = m_axis_tvalid && !m_axis_tready;

    // A pending result is not withdrawn before its transfer.
    `TBC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_busy, m_axis_tvalid)

    // Only one item is in work at a time.
    `TBC_ASSERT_NEXT(a_one_item, clk, rst_n, in_xfer, !s_axis_tready)

    // A write item taken with the output empty reports zero after ST_RESP.
    `TBC_ASSERT_NEXT(a_write_result, clk, rst_n,
        in_xfer && (s_axis_tuser == ACT_WRITE) && !m_axis_tvalid,
        ##1 (m_axis_tvalid && (m_axis_tdata[0] == 1'b0)))

    // A new result appears only when the block has been busy with an item.
    `TBC_ASSERT_SAME(a_result_source, clk, rst_n, $rose(m_axis_tvalid),
        !$past(s_axis_tready))

endmodule

bind tilemap_box_collision_unit tbc_checker u_tbc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

@@ sim/tilemap_box_collision_unit_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tilemap_box_collision_unit_tb
// Self-checking bench for the tile map box collision unit. A short table of
// tile writes and box queries at the map corners, at tile edges and with
// zero-size boxes runs first. Random traffic follows, aimed mostly at a small
// window of the map so that queries find both filled and open tiles. Each
// result is checked against a pinned value or a behavioral copy of the map and
// the collision test, under four idling patterns and several empty tile codes.
// ----------------------------------------------------------------------------

module tilemap_box_collision_unit_tb;

    import tbc_pkg::*;

    localparam int TILE_W         = 32;
    localparam int TILE_H         = 32;
    localparam int MAP_COLS       = 64;
    localparam int MAP_ROWS       = 64;
    localparam int MAP_AW         = $clog2(MAP_COLS*MAP_ROWS);
    localparam int PHASES         = 4;
    localparam int OPS_PER_PHASE  = 375;
    localparam int DIR_ROWS       = 20;
    localparam int QUIET_LIMIT    = 20000;
    localparam int MAX_SHOWN      = 10;
    localparam int COORD_MAX      = (1 << COORD_W) - 1;

    typedef struct packed {
        logic               act;
        logic [GRID_W-1:0]  col;
        logic [GRID_W-1:0]  row;
        logic [TYPE_W-1:0]  tile_type;
        logic [COORD_W-1:0] box_x;
        logic [COORD_W-1:0] box_y;
        logic [DIM_W-1:0]   box_w;
        logic [DIM_W-1:0]   box_h;
    } tile_op_t;

    // A pinned row carries its own expected touching value.
    typedef struct packed {
        logic     pinned;
        logic     touch;
        tile_op_t op;
    } dir_row_t;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_wr_en;
    logic [TYPE_W-1:0]    cfg_wr_data;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata;
    logic                 s_axis_tuser;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;

    // Behavioral copy of the map and the empty tile code.
    logic [TYPE_W-1:0] tile_grid [MAP_COLS*MAP_ROWS];
    logic [TYPE_W-1:0] empty_code;
    logic              touch_due [$];

    int src_idle_pct   = 0;
    int sink_stall_pct = 0;
    int win_col        = 0;
    int win_row        = 0;
    int ops_sent       = 0;
    int queries_sent   = 0;
    int hits_due       = 0;
    int results_seen   = 0;
    int mismatches     = 0;
    int quiet_cycles   = 0;

    dir_row_t dir_table [DIR_ROWS] = '{
        // Cleared map: nothing can touch.
        '{1'b1, 1'b0, '{ACT_QUERY, 6'd0,  6'd0,  4'd0,  11'd0,    11'd0,    8'd255, 8'd255}},
        '{1'b1, 1'b0, '{ACT_QUERY, 6'd0,  6'd0,  4'd0,  11'd2047, 11'd2047, 8'd255, 8'd255}},
        '{1'b1, 1'b0, '{ACT_QUERY, 6'd0,  6'd0,  4'd0,  11'd0,    11'd0,    8'd0,   8'd0}},
        // Writes always answer with touching low.
        '{1'b1, 1'b0, '{ACT_WRITE, 6'd0,  6'd0,  4'd15, 11'd0,    11'd0,    8'd0,   8'd0}},
        '{1'b1, 1'b0, '{ACT_WRITE, 6'd63, 6'd63, 4'd1,  11'd0,    11'd0,    8'd0,   8'd0}},
        '{1'b1, 1'b0, '{ACT_WRITE, 6'd5,  6'd7,  4'd9,  11'd0,    11'd0,    8'd0,   8'd0}},
        '{1'b1, 1'b0, '{ACT_WRITE, 6'd63, 6'd0,  4'd6,  11'd0,    11'd0,    8'd0,   8'd0}},
        '{1'b0, 1'b0, '{ACT_QUERY, 6'd0,  6'd0,  4'd0,  11'd0,    11'd0,    8'd1,   8'd1}},
        // Shares only the right edge, then only the bottom edge, of the corner tile.
        '{1'b0, 1'b0, '{ACT_QUERY, 6'd0,  6'd0,  4'd0,  11'd32,   11'd0,    8'd10,  8'd10}},
        '{1'b0, 1'b0, '{ACT_QUERY, 6'd0,  6'd0,  4'd0,  11'd0,    11'd32,   8'd31,  8'd10}},
        '{1'b0, 1'b0, '{ACT_QUERY, 6'd0,  6'd0,  4'd0,  11'd2016, 11'd2016, 8'd255, 8'd255}},
        // Zero-size boxes, inside a tile and on a tile corner.
        '{1'b0, 1'b0, '{ACT_QUERY, 6'd0,  6'd0,  4'd0,  11'd2047, 11'd2047, 8'd0,   8'd0}},
        '{1'b0, 1'b0, '{ACT_QUERY, 6'd0,  6'd0,  4'd0,  11'd2016, 11'd2016, 8'd0,   8'd0}},
        '{1'b0, 1'b0, '{ACT_QUERY, 6'd0,  6'd0,  4'd0,  11'd128,  11'd192,  8'd32,  8'd32}},
        '{1'b0, 1'b0, '{ACT_QUERY, 6'd0,  6'd0,  4'd0,  11'd129,  11'd193,  8'd32,  8'd32}},
        '{1'b0, 1'b0, '{ACT_QUERY, 6'd0,  6'd0,  4'd0,  11'd170,  11'd230,  8'd0,   8'd7}},
        // Candidate columns run past the right edge of the grid.
        '{1'b0, 1'b0, '{ACT_QUERY, 6'd0,  6'd0,  4'd0,  11'd2040, 11'd0,    8'd255, 8'd8}},
        '{1'b1, 1'b0, '{ACT_WRITE, 6'd5,  6'd7,  4'd0,  11'd0,    11'd0,    8'd0,   8'd0}},
        '{1'b0, 1'b0, '{ACT_QUERY, 6'd0,  6'd0,  4'd0,  11'd129,  11'd193,  8'd32,  8'd32}},
        '{1'b0, 1'b0, '{ACT_QUERY, 6'd0,  6'd0,  4'd0,  11'd1000, 11'd1000, 8'd255, 8'd255}}
    };

    tilemap_box_collision_unit #(
        .TILE_W   (TILE_W),
        .TILE_H   (TILE_H),
        .MAP_COLS (MAP_COLS),
        .MAP_ROWS (MAP_ROWS)
    ) uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #1 clk = ~clk;

    // Scans the candidate tiles around the box; cells off the grid are skipped.
    function automatic logic box_touches_map(input tile_op_t op);
        int x0;
        int y0;
        int wd;
        int ht;
        int c;
        int r;
        int tx;
        int ty;
        x0 = int'(op.box_x);
        y0 = int'(op.box_y);
        wd = int'(op.box_w);
        ht = int'(op.box_h);
        for (c = x0 / TILE_W - 1; c <= (x0 + wd) / TILE_W; c++)
        begin
            if (c < 0 || c >= MAP_COLS)
                continue;
            for (r = y0 / TILE_H - 1; r <= (y0 + ht) / TILE_H; r++)
            begin
                if (r < 0 || r >= MAP_ROWS)
                    continue;
                if (tile_grid[MAP_AW'(r*MAP_COLS + c)] == empty_code)
                    continue;
                tx = c * TILE_W;
                ty = r * TILE_H;
                if (y0 + ht > ty && y0 < ty + TILE_H && x0 + wd > tx && x0 < tx + TILE_W)
                    return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    // Updates the map copy and returns the touching value the block must give.
    function automatic logic apply_op(input tile_op_t op);
        if (op.act == ACT_WRITE)
        begin
            if (op.col < MAP_COLS && op.row < MAP_ROWS)
                tile_grid[MAP_AW'(int'(op.row)*MAP_COLS + int'(op.col))] = op.tile_type;
            return 1'b0;
        end
        return box_touches_map(op);
    endfunction

    // Random item, mostly aimed at the current window of the map.
    function automatic tile_op_t random_op();
        tile_op_t    op;
        logic [63:0] raw;
        int          px;
        int          py;
        raw = {$urandom, $urandom};
        op = raw[$bits(tile_op_t)-1:0];
        op.act = ($urandom_range(0, 99) < 35) ? ACT_WRITE : ACT_QUERY;
        if (op.act == ACT_WRITE)
        begin
            if ($urandom_range(0, 3) != 0)
            begin
                op.col = GRID_W'(win_col + int'($urandom_range(0, 7)));
                op.row = GRID_W'(win_row + int'($urandom_range(0, 7)));
            end
            if ($urandom_range(0, 3) == 0)
                op.tile_type = empty_code;
        end
        else if ($urandom_range(0, 3) != 0)
        begin
            px = win_col*TILE_W + int'($urandom_range(0, 9*TILE_W)) - TILE_W;
            py = win_row*TILE_H + int'($urandom_range(0, 9*TILE_H)) - TILE_H;
            op.box_x = COORD_W'((px < 0) ? 0 : (px > COORD_MAX) ? COORD_MAX : px);
            op.box_y = COORD_W'((py < 0) ? 0 : (py > COORD_MAX) ? COORD_MAX : py);
            if ($urandom_range(0, 7) != 0)
            begin
                op.box_w = DIM_W'($urandom_range(0, 60));
                op.box_h = DIM_W'($urandom_range(0, 60));
            end
        end
        return op;
    endfunction

    // Offers one item from a falling edge and returns at the falling edge after
    // its transfer, leaving tvalid high so back-to-back items need no toggle.
    task automatic send_op(input tile_op_t op, input logic pinned, input logic pin_touch);
        logic touch;
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op.act;
        s_axis_tdata  <= {2'b00, op.box_h, op.box_w, op.box_y, op.box_x,
                          op.tile_type, op.row, op.col};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        touch = apply_op(op);
        if (pinned)
            touch = pin_touch;
        touch_due.push_back(touch);
        ops_sent++;
        if (op.act == ACT_QUERY)
        begin
            queries_sent++;
            hits_due += touch;
        end
        @(negedge clk);
    endtask

    // The register is only written once every result has come back.
    task automatic set_empty_code(input logic [TYPE_W-1:0] code);
        s_axis_tvalid <= 1'b0;
        while (touch_due.size() != 0)
            @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= code;
        @(negedge clk);
        cfg_wr_en  <= 1'b0;
        empty_code = code;
    endtask

    always @(negedge clk)
        m_axis_tready <= ($urandom_range(0, 99) >= sink_stall_pct);

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            results_seen++;
            if (touch_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_SHOWN)
                    $display("result %0d arrived with nothing outstanding, touching=%0b",
                             results_seen, m_axis_tdata[0]);
            end
            else if (m_axis_tdata[0] !== touch_due[0])
            begin
                mismatches++;
                if (mismatches <= MAX_SHOWN)
                    $display("result %0d: touching expected %0b, got %0b",
                             results_seen, touch_due[0], m_axis_tdata[0]);
                void'(touch_due.pop_front());
            end
            else
            begin
                void'(touch_due.pop_front());
            end
        end
    end

    // Counts cycles without any transfer; the reset sweep fits well inside.
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("no transfer for %0d cycles, %0d results outstanding",
                     QUIET_LIMIT, touch_due.size());
            $display("tilemap_box_collision_unit: mismatch");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        int                src_pct [PHASES];
        int                sink_pct [PHASES];
        logic [TYPE_W-1:0] phase_code [PHASES];
        src_pct    = '{0, 52, 0, 21};
        sink_pct   = '{0, 0, 52, 21};
        phase_code = '{4'd15, 4'($urandom_range(1, 14)), 4'd0, 4'($urandom_range(1, 14))};

        tile_grid     = '{default: '0};
        empty_code    = '0;
        rst_n         = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_wr_data   = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = ACT_WRITE;

        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        set_empty_code(4'd0);

        foreach (dir_table[i])
            send_op(dir_table[i].op, dir_table[i].pinned, dir_table[i].touch);

        foreach (phase_code[ph])
        begin
            set_empty_code(phase_code[ph]);
            src_idle_pct   = src_pct[ph];
            sink_stall_pct = sink_pct[ph];
            for (int n = 0; n < OPS_PER_PHASE; n++)
            begin
                // Move the window now and then, often onto a corner of the map.
                if (n % 125 == 0)
                begin
                    case ($urandom_range(0, 2))
                        0:       win_col = 0;
                        1:       win_col = MAP_COLS - 8;
                        default: win_col = $urandom_range(0, MAP_COLS - 8);
                    endcase
                    case ($urandom_range(0, 2))
                        0:       win_row = 0;
                        1:       win_row = MAP_ROWS - 8;
                        default: win_row = $urandom_range(0, MAP_ROWS - 8);
                    endcase
                end
                send_op(random_op(), 1'b0, 1'b0);
            end
        end

        s_axis_tvalid <= 1'b0;
        while (touch_due.size() != 0)
            @(negedge clk);
        repeat (200) @(negedge clk);

        $display("%0d items sent (%0d queries, %0d touching), %0d results checked,",
                 ops_sent, queries_sent, hits_due, results_seen);
        $display("over four idling patterns with empty codes 0, 15, %0d and %0d",
                 phase_code[1], phase_code[3]);
        if (mismatches == 0)
            $display("tilemap_box_collision_unit: match");
        else
            $display("tilemap_box_collision_unit: mismatch");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+hw/rtl
hw/rtl/tbc_pkg.sv
hw/rtl/tbc_div.sv
hw/rtl/tbc_map.sv
hw/rtl/tilemap_box_collision_unit.sv
hw/rtl/tbc_checker.sv
sim/tilemap_box_collision_unit_tb.sv
